[rtl/rcpw_pkg.sv]
// Shared types and constants for the RC pulse width window switch.
`default_nettype none

package rcpw_pkg;

    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int WIDTH_BITS = 16;
    localparam int SPAN_BITS = 8;
    localparam int NUM_CH = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH0_WINDOW_START = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH1_WINDOW_START = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SPAN = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CH2_THRESHOLD = 3'd5;

    // Reset values of the configuration registers
    localparam logic [WIDTH_BITS-1:0] LOW_LIMIT_RESET = 16'd283;
    localparam logic [WIDTH_BITS-1:0] HIGH_LIMIT_RESET = 16'd480;
    localparam logic [WIDTH_BITS-1:0] CH0_WINDOW_START_RESET = 16'd380;
    localparam logic [WIDTH_BITS-1:0] CH1_WINDOW_START_RESET = 16'd377;
    localparam logic [SPAN_BITS-1:0] WINDOW_SPAN_RESET = 8'd3;
    localparam logic [WIDTH_BITS-1:0] CH2_THRESHOLD_RESET = 16'd283;

    localparam logic [NUM_CH-1:0] SWITCH_RESET = 3'b011;

    // Decision limits handed to one channel
    typedef struct packed {
        logic [WIDTH_BITS-1:0] low_limit;
        logic [WIDTH_BITS-1:0] high_limit;
        logic [WIDTH_BITS-1:0] window_start;
        logic [SPAN_BITS-1:0]  window_span;
        logic [WIDTH_BITS-1:0] threshold;
    } ch_cfg_t;

endpackage

`default_nettype wire

[rtl/rcpw_channel.sv]
// One pulse channel: edge detect, rise stamp, width measurement and switch decision.
`default_nettype none

module rcpw_channel #(
    parameter int COUNT_BITS = 16,
    parameter bit THRESH_MODE = 1'b0,
    parameter bit SWITCH_INIT = 1'b0
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic                           level,
    input  wire logic [COUNT_BITS-1:0]          tick,
    input  wire rcpw_pkg::ch_cfg_t              cfg,
    output logic                                switch_next,
    output logic                                done,
    output logic [rcpw_pkg::WIDTH_BITS-1:0]     width_next
);

    localparam int CMP_BITS = (COUNT_BITS > rcpw_pkg::WIDTH_BITS + 1) ?
                              COUNT_BITS : rcpw_pkg::WIDTH_BITS + 1;

    logic                       prev_reg;
    logic                       in_pulse_reg;
    logic [COUNT_BITS-1:0]      rise_stamp_reg;
    logic [COUNT_BITS-1:0]      last_width_reg;
    logic                       switch_reg;

    logic                       rise;
    logic                       fall;
    logic [COUNT_BITS-1:0]      width;
    logic [CMP_BITS-1:0]        width_ext;
    logic [rcpw_pkg::WIDTH_BITS:0] window_top;
    logic                       in_window;
    logic                       hit;
    logic [COUNT_BITS-1:0]      last_width_next;

    assign rise = level & ~prev_reg & ~in_pulse_reg;
    assign fall = ~level & prev_reg & in_pulse_reg;
    assign width = tick - rise_stamp_reg;
    assign width_ext = CMP_BITS'(width);

    // Window top is formed one bit wider so it never wraps
    assign window_top = (rcpw_pkg::WIDTH_BITS + 1)'(cfg.window_start)
                      + (rcpw_pkg::WIDTH_BITS + 1)'(cfg.window_span);
    assign in_window = (width_ext >= CMP_BITS'(cfg.window_start))
                    && (width_ext <= CMP_BITS'(window_top));

    always_comb
    begin
        if (THRESH_MODE)
        begin
            hit = width_ext > CMP_BITS'(cfg.threshold);
        end
        else
        begin
            hit = in_window
               || (width_ext < CMP_BITS'(cfg.low_limit))
               || (width_ext > CMP_BITS'(cfg.high_limit));
        end
    end

    assign done = fall;
    assign switch_next = fall ? hit : switch_reg;
    assign last_width_next = fall ? width : last_width_reg;

    // Report width saturated to the output field
    generate
        if (COUNT_BITS > rcpw_pkg::WIDTH_BITS)
        begin : g_sat
            assign width_next = (|last_width_next[COUNT_BITS-1:rcpw_pkg::WIDTH_BITS]) ?
                                {rcpw_pkg::WIDTH_BITS{1'b1}} :
                                last_width_next[rcpw_pkg::WIDTH_BITS-1:0];
        end
        else
        begin : g_ext
            assign width_next = rcpw_pkg::WIDTH_BITS'(last_width_next);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= 1'b0;
            in_pulse_reg   <= 1'b0;
            rise_stamp_reg <= '0;
            last_width_reg <= '0;
            switch_reg     <= SWITCH_INIT;
        end
        else if (step)
        begin
            prev_reg       <= level;
            last_width_reg <= last_width_next;
            switch_reg     <= switch_next;
            if (rise)
            begin
                rise_stamp_reg <= tick;
                in_pulse_reg   <= 1'b1;
            end
            else if (fall)
            begin
                in_pulse_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/rc_pulse_width_window_switch_core.sv]
// Latency: a result appears in the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle; the result register lets a new tick in
// whenever it is empty or being drained in the same cycle.
// Reset: tick count, edge state and widths clear, switches go to 011,
// configuration registers take their default limits.
`default_nettype none

module rc_pulse_width_window_switch_core #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [rcpw_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [rcpw_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [rcpw_pkg::NUM_CH-1:0]            pin_levels,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [rcpw_pkg::NUM_CH-1:0]                 switch_bits,
    output logic [rcpw_pkg::NUM_CH-1:0]                 measured_mask,
    output logic [rcpw_pkg::WIDTH_BITS-1:0]             width_ch0,
    output logic [rcpw_pkg::WIDTH_BITS-1:0]             width_ch1,
    output logic [rcpw_pkg::WIDTH_BITS-1:0]             width_ch2
);

    logic [rcpw_pkg::WIDTH_BITS-1:0] low_limit_reg;
    logic [rcpw_pkg::WIDTH_BITS-1:0] high_limit_reg;
    logic [rcpw_pkg::WIDTH_BITS-1:0] ch0_start_reg;
    logic [rcpw_pkg::WIDTH_BITS-1:0] ch1_start_reg;
    logic [rcpw_pkg::SPAN_BITS-1:0]  span_reg;
    logic [rcpw_pkg::WIDTH_BITS-1:0] ch2_thresh_reg;

    logic [COUNT_BITS-1:0]           tick_reg;
    logic                            out_valid_reg;
    logic [rcpw_pkg::NUM_CH-1:0]     switch_reg;
    logic [rcpw_pkg::NUM_CH-1:0]     mask_reg;
    logic [rcpw_pkg::WIDTH_BITS-1:0] width0_reg;
    logic [rcpw_pkg::WIDTH_BITS-1:0] width1_reg;
    logic [rcpw_pkg::WIDTH_BITS-1:0] width2_reg;

    logic                            take;
    logic                            out_valid_next;
    rcpw_pkg::ch_cfg_t               cfg0;
    rcpw_pkg::ch_cfg_t               cfg1;
    rcpw_pkg::ch_cfg_t               cfg2;
    logic [rcpw_pkg::NUM_CH-1:0]     switch_next;
    logic [rcpw_pkg::NUM_CH-1:0]     done;
    logic [rcpw_pkg::WIDTH_BITS-1:0] width0_next;
    logic [rcpw_pkg::WIDTH_BITS-1:0] width1_next;
    logic [rcpw_pkg::WIDTH_BITS-1:0] width2_next;

    assign in_stall = out_valid_reg & out_stall;
    assign take = in_valid & ~in_stall;
    assign out_valid_next = take | (out_valid_reg & out_stall);

    assign cfg0 = '{low_limit: low_limit_reg, high_limit: high_limit_reg,
                    window_start: ch0_start_reg, window_span: span_reg,
                    threshold: ch2_thresh_reg};
    assign cfg1 = '{low_limit: low_limit_reg, high_limit: high_limit_reg,
                    window_start: ch1_start_reg, window_span: span_reg,
                    threshold: ch2_thresh_reg};
    assign cfg2 = '{low_limit: low_limit_reg, high_limit: high_limit_reg,
                    window_start: ch0_start_reg, window_span: span_reg,
                    threshold: ch2_thresh_reg};

    rcpw_channel #(
        .COUNT_BITS  (COUNT_BITS),
        .THRESH_MODE (1'b0),
        .SWITCH_INIT (rcpw_pkg::SWITCH_RESET[0])
    ) u_ch0 (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (take),
        .level       (pin_levels[0]),
        .tick        (tick_reg),
        .cfg         (cfg0),
        .switch_next (switch_next[0]),
        .done        (done[0]),
        .width_next  (width0_next)
    );

    rcpw_channel #(
        .COUNT_BITS  (COUNT_BITS),
        .THRESH_MODE (1'b0),
        .SWITCH_INIT (rcpw_pkg::SWITCH_RESET[1])
    ) u_ch1 (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (take),
        .level       (pin_levels[1]),
        .tick        (tick_reg),
        .cfg         (cfg1),
        .switch_next (switch_next[1]),
        .done        (done[1]),
        .width_next  (width1_next)
    );

    rcpw_channel #(
        .COUNT_BITS  (COUNT_BITS),
        .THRESH_MODE (1'b1),
        .SWITCH_INIT (rcpw_pkg::SWITCH_RESET[2])
    ) u_ch2 (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (take),
        .level       (pin_levels[2]),
        .tick        (tick_reg),
        .cfg         (cfg2),
        .switch_next (switch_next[2]),
        .done        (done[2]),
        .width_next  (width2_next)
    );

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= rcpw_pkg::LOW_LIMIT_RESET;
            high_limit_reg <= rcpw_pkg::HIGH_LIMIT_RESET;
            ch0_start_reg  <= rcpw_pkg::CH0_WINDOW_START_RESET;
            ch1_start_reg  <= rcpw_pkg::CH1_WINDOW_START_RESET;
            span_reg       <= rcpw_pkg::WINDOW_SPAN_RESET;
            ch2_thresh_reg <= rcpw_pkg::CH2_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcpw_pkg::REG_LOW_LIMIT:        low_limit_reg  <= cfg_data;
                rcpw_pkg::REG_HIGH_LIMIT:       high_limit_reg <= cfg_data;
                rcpw_pkg::REG_CH0_WINDOW_START: ch0_start_reg  <= cfg_data;
                rcpw_pkg::REG_CH1_WINDOW_START: ch1_start_reg  <= cfg_data;
                rcpw_pkg::REG_WINDOW_SPAN:
                    span_reg <= cfg_data[rcpw_pkg::SPAN_BITS-1:0];
                rcpw_pkg::REG_CH2_THRESHOLD:    ch2_thresh_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Tick counter and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                tick_reg <= tick_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            switch_reg <= switch_next;
            mask_reg   <= done;
            width0_reg <= width0_next;
            width1_reg <= width1_next;
            width2_reg <= width2_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign switch_bits   = switch_reg;
    assign measured_mask = mask_reg;
    assign width_ch0     = width0_reg;
    assign width_ch1     = width1_reg;
    assign width_ch2     = width2_reg;

endmodule

`default_nettype wire

[bench/tb_rc_pulse_width_window_switch_core.sv]
// Self-checking bench for the RC pulse width window switch core.
`timescale 1ns / 1ps

module tb_rc_pulse_width_window_switch_core;

    localparam int CNT_BITS = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 60;
    localparam logic [rcpw_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [rcpw_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [rcpw_pkg::NUM_CH-1:0]     switch_bits;
        logic [rcpw_pkg::NUM_CH-1:0]     measured_mask;
        logic [rcpw_pkg::WIDTH_BITS-1:0] width_ch0;
        logic [rcpw_pkg::WIDTH_BITS-1:0] width_ch1;
        logic [rcpw_pkg::WIDTH_BITS-1:0] width_ch2;
    } tick_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [rcpw_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [rcpw_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic [rcpw_pkg::NUM_CH-1:0]         pin_levels;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [rcpw_pkg::NUM_CH-1:0]         switch_bits;
    logic [rcpw_pkg::NUM_CH-1:0]         measured_mask;
    logic [rcpw_pkg::WIDTH_BITS-1:0]     width_ch0;
    logic [rcpw_pkg::WIDTH_BITS-1:0]     width_ch1;
    logic [rcpw_pkg::WIDTH_BITS-1:0]     width_ch2;

    // Decoder state as predicted
    logic [CNT_BITS-1:0]             tick_now;
    logic [rcpw_pkg::NUM_CH-1:0]     pins_before;
    logic [rcpw_pkg::NUM_CH-1:0]     pulse_open;
    logic [rcpw_pkg::NUM_CH-1:0]     switch_now;
    logic [CNT_BITS-1:0]             rise_at [rcpw_pkg::NUM_CH];
    logic [CNT_BITS-1:0]             width_last [rcpw_pkg::NUM_CH];
    logic [rcpw_pkg::WIDTH_BITS-1:0] lim_low, lim_high, win0_start, win1_start, ch2_thr;
    logic [rcpw_pkg::SPAN_BITS-1:0]  win_span;

    tick_result_t expected_ticks[$];
    int           favored_widths[$];
    logic [rcpw_pkg::NUM_CH-1:0] gen_level = '0;
    int           gen_left [rcpw_pkg::NUM_CH] = '{0, 0, 0};

    int  error_count = 0;
    int  cycle_count = 0;
    int  sender_gap_pct = 0;
    int  stall_pct = 0;
    int  hold_trigger = 0;
    int  hold_seen = 0;
    int  hold_count = 0;

    rc_pulse_width_window_switch_core #(
        .COUNT_BITS(CNT_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pin_levels(pin_levels),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .switch_bits(switch_bits),
        .measured_mask(measured_mask),
        .width_ch0(width_ch0),
        .width_ch1(width_ch1),
        .width_ch2(width_ch2)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_count = HOLD_CYCLES;
        end
        if (hold_count > 0)
        begin
            hold_count = hold_count - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ticks.size() == 0)
            begin
                report_mismatch("unexpected transaction, switch_bits", switch_bits, 0);
            end
            else
            begin
                want = expected_ticks.pop_front();
                if (switch_bits !== want.switch_bits)
                    report_mismatch("switch_bits", switch_bits, want.switch_bits);
                if (measured_mask !== want.measured_mask)
                    report_mismatch("measured_mask", measured_mask, want.measured_mask);
                if (width_ch0 !== want.width_ch0)
                    report_mismatch("width_ch0", width_ch0, want.width_ch0);
                if (width_ch1 !== want.width_ch1)
                    report_mismatch("width_ch1", width_ch1, want.width_ch1);
                if (width_ch2 !== want.width_ch2)
                    report_mismatch("width_ch2", width_ch2, want.width_ch2);
            end
        end
    end

    function automatic logic switch_decision(input int ch, input logic [CNT_BITS-1:0] w);
        logic [rcpw_pkg::WIDTH_BITS:0]   top;
        logic [rcpw_pkg::WIDTH_BITS-1:0] start;
        if (ch == 2)
            return w > ch2_thr;
        start = (ch == 0) ? win0_start : win1_start;
        // window end is one bit wider so it never wraps
        top = {1'b0, start} + win_span;
        return (w >= start && w <= top) || w < lim_low || w > lim_high;
    endfunction

    function automatic logic [rcpw_pkg::WIDTH_BITS-1:0] clip_width(
        input logic [CNT_BITS-1:0] w);
        logic [31:0] wide;
        wide = 32'(w);
        return (wide > 32'hFFFF) ? 16'hFFFF : wide[rcpw_pkg::WIDTH_BITS-1:0];
    endfunction

    task automatic decode_tick(input logic [rcpw_pkg::NUM_CH-1:0] pins);
        tick_result_t                r;
        logic [rcpw_pkg::NUM_CH-1:0] done;
        logic [CNT_BITS-1:0]         w;
        int                          ch;
        done = '0;
        for (ch = 0; ch < rcpw_pkg::NUM_CH; ch++)
        begin
            if (pins[ch] && !pins_before[ch] && !pulse_open[ch])
            begin
                rise_at[ch] = tick_now;
                pulse_open[ch] = 1'b1;
            end
            else if (!pins[ch] && pins_before[ch] && pulse_open[ch])
            begin
                w = tick_now - rise_at[ch];
                width_last[ch] = w;
                pulse_open[ch] = 1'b0;
                done[ch] = 1'b1;
                switch_now[ch] = switch_decision(ch, w);
            end
        end
        pins_before = pins;
        tick_now = tick_now + 1'b1;
        r.switch_bits = switch_now;
        r.measured_mask = done;
        r.width_ch0 = clip_width(width_last[0]);
        r.width_ch1 = clip_width(width_last[1]);
        r.width_ch2 = clip_width(width_last[2]);
        expected_ticks.push_back(r);
    endtask

    task automatic reset_decoder();
        int ch;
        tick_now = '0;
        pins_before = '0;
        pulse_open = '0;
        switch_now = rcpw_pkg::SWITCH_RESET;
        for (ch = 0; ch < rcpw_pkg::NUM_CH; ch++)
        begin
            rise_at[ch] = '0;
            width_last[ch] = '0;
        end
        lim_low = rcpw_pkg::LOW_LIMIT_RESET;
        lim_high = rcpw_pkg::HIGH_LIMIT_RESET;
        win0_start = rcpw_pkg::CH0_WINDOW_START_RESET;
        win1_start = rcpw_pkg::CH1_WINDOW_START_RESET;
        win_span = rcpw_pkg::WINDOW_SPAN_RESET;
        ch2_thr = rcpw_pkg::CH2_THRESHOLD_RESET;
    endtask

    // Offer one tick; return at the edge that accepts it, valid left high
    task automatic send_tick(input logic [rcpw_pkg::NUM_CH-1:0] pins);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            pin_levels <= rcpw_pkg::NUM_CH'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pin_levels <= pins;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_tick(pins);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rcpw_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [rcpw_pkg::CFG_DATA_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            rcpw_pkg::REG_LOW_LIMIT:        lim_low = data;
            rcpw_pkg::REG_HIGH_LIMIT:       lim_high = data;
            rcpw_pkg::REG_CH0_WINDOW_START: win0_start = data;
            rcpw_pkg::REG_CH1_WINDOW_START: win1_start = data;
            rcpw_pkg::REG_WINDOW_SPAN:      win_span = data[rcpw_pkg::SPAN_BITS-1:0];
            rcpw_pkg::REG_CH2_THRESHOLD:    ch2_thr = data;
            default:                        ;
        endcase
    endtask

    task automatic write_limits(input int lo, input int hi, input int w0, input int w1,
                                input int span, input int thr);
        write_reg(rcpw_pkg::REG_LOW_LIMIT, 16'(lo));
        write_reg(rcpw_pkg::REG_HIGH_LIMIT, 16'(hi));
        write_reg(rcpw_pkg::REG_CH0_WINDOW_START, 16'(w0));
        write_reg(rcpw_pkg::REG_CH1_WINDOW_START, 16'(w1));
        write_reg(rcpw_pkg::REG_WINDOW_SPAN, 16'(span));
        write_reg(rcpw_pkg::REG_CH2_THRESHOLD, 16'(thr));
    endtask

    // Bias pulse widths toward the decision boundaries of the current limits
    task automatic favor_limit_edges();
        int cand[$];
        favored_widths.delete();
        cand = '{int'(lim_low) - 1, int'(lim_low), int'(lim_high), int'(lim_high) + 1,
                 int'(win0_start) - 1, int'(win0_start), int'(win0_start) + int'(win_span),
                 int'(win0_start) + int'(win_span) + 1,
                 int'(win1_start) - 1, int'(win1_start), int'(win1_start) + int'(win_span),
                 int'(win1_start) + int'(win_span) + 1, int'(ch2_thr), int'(ch2_thr) + 1};
        foreach (cand[i])
            if (cand[i] >= 1)
                favored_widths.push_back(cand[i]);
    endtask

    // Next pin sample from per-channel pulse trains, with rare one-tick glitches
    task automatic pick_pins(output logic [rcpw_pkg::NUM_CH-1:0] pins, input int hi_min,
                             input int hi_max, input int lo_min, input int lo_max);
        int ch;
        for (ch = 0; ch < rcpw_pkg::NUM_CH; ch++)
        begin
            if (gen_left[ch] <= 0)
            begin
                gen_level[ch] = ~gen_level[ch];
                if (!gen_level[ch])
                    gen_left[ch] = $urandom_range(lo_max, lo_min);
                else if (favored_widths.size() > 0 && $urandom_range(1) == 1)
                    gen_left[ch] = favored_widths[$urandom_range(favored_widths.size() - 1)];
                else
                    gen_left[ch] = $urandom_range(hi_max, hi_min);
            end
            gen_left[ch]--;
        end
        pins = gen_level;
        if ($urandom_range(99) < 4)
            pins[$urandom_range(rcpw_pkg::NUM_CH - 1)] ^= 1'b1;
    endtask

    task automatic run_pulses(input int n_ticks, input int hi_min, input int hi_max,
                              input int lo_min, input int lo_max);
        logic [rcpw_pkg::NUM_CH-1:0] pins;
        repeat (n_ticks)
        begin
            pick_pins(pins, hi_min, hi_max, lo_min, lo_max);
            send_tick(pins);
        end
    endtask

    // Pins high on the first tick, short pulses and every level combination
    task automatic test_reset_edges();
        logic [rcpw_pkg::NUM_CH-1:0] seq[$];
        seq = '{3'b111, 3'b111, 3'b000, 3'b001, 3'b010, 3'b100, 3'b011, 3'b110, 3'b101,
                3'b010, 3'b111, 3'b000, 3'b000, 3'b111, 3'b011, 3'b001, 3'b000, 3'b100,
                3'b100, 3'b110, 3'b111, 3'b101, 3'b000};
        foreach (seq[i])
            send_tick(seq[i]);
        wait_idle();
    endtask

    // Short pulses under the reset limits: below the low limit and the ch2 threshold
    task automatic test_default_limits();
        favored_widths.delete();
        run_pulses(40, 1, 10, 1, 10);
        wait_idle();
    endtask

    task automatic test_small_windows();
        // ignored indexes, then a span write with junk in its upper byte
        write_reg(REG_SPARE_6, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'hFFFF);
        write_limits(8, 40, 20, 17, 0, 25);
        write_reg(rcpw_pkg::REG_WINDOW_SPAN, 16'hFF03);
        favor_limit_edges();
        run_pulses(100, 1, 50, 1, 8);
        wait_idle();
    endtask

    task automatic test_random_limits();
        int lo;
        repeat (3)
        begin
            lo = $urandom_range(30, 0);
            write_limits(lo, $urandom_range(60, lo), $urandom_range(60, 0),
                         $urandom_range(60, 0), $urandom_range(10, 0), $urandom_range(60, 0));
            favor_limit_edges();
            run_pulses(40, 1, 70, 1, 8);
            wait_idle();
        end
    endtask

    task automatic test_input_backpressure();
        write_limits(5, 30, 12, 14, 2, 9);
        favor_limit_edges();
        run_pulses(30, 1, 35, 1, 6);
        // stall the output long enough for the core to push back on its input
        hold_trigger++;
        run_pulses(70, 1, 35, 1, 6);
        wait_idle();
    endtask

    task automatic test_extreme_limits();
        // every width is below 65535 or above 0: all channels on
        write_limits(65535, 0, 0, 65535, 0, 0);
        favored_widths.delete();
        run_pulses(40, 1, 6, 1, 4);
        wait_idle();
        // ch0 window sits at the top of the range and must not wrap onto short widths
        write_limits(0, 65535, 65535, 0, 255, 65534);
        run_pulses(30, 1, 12, 1, 4);
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pin_levels = '0;
        reset_decoder();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_gap_pct = 37;
        stall_pct = 76;
        test_reset_edges();
        test_default_limits();
        test_small_windows();

        sender_gap_pct = 76;
        stall_pct = 37;
        test_random_limits();

        sender_gap_pct = 0;
        stall_pct = 0;
        test_input_backpressure();
        test_extreme_limits();

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
